>>> hdl/rmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared widths, codes and sideband types of the matrix-to-quaternion pipe.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int EW         = 16;                    // element and result width
  localparam int AW         = 19;                    // square-root argument width
  localparam int OW         = 17;                    // off-diagonal sum width
  localparam int ARG_W      = 17;                    // magnitude bits of a positive argument
  localparam int SQ_IN_W    = ARG_W + FRAC_BITS - 2; // radicand width
  localparam int SQ_W       = 30;                    // radicand datapath width
  localparam int SQ_STEPS   = (SQ_IN_W + 1) / 2;     // one root bit per stage
  localparam int ROOT_W     = SQ_STEPS;
  localparam int DEN_W      = ROOT_W + 2;
  localparam int NUM_W      = OW + FRAC_BITS;
  localparam int QW         = 17;                    // quotient bits kept
  localparam int CMP_W      = DEN_W + QW;
  localparam int DIV_STEPS  = QW;
  localparam int LANES      = 3;

  typedef enum logic [1:0] {
    BIG_X = 2'd0,
    BIG_Y = 2'd1,
    BIG_Z = 2'd2,
    BIG_W = 2'd3
  } big_t;

  typedef struct packed {
    big_t big;
    logic degen;
  } meta_t;

  typedef struct packed {
    logic [LANES-1:0][OW-1:0] d;
    meta_t                    meta;
  } side_t;

  typedef struct packed {
    logic [ROOT_W-1:0]        c;
    logic [LANES-1:0][QW-1:0] q;
    logic [LANES-1:0]         neg;
    logic [LANES-1:0]         ovf;
    meta_t                    meta;
  } div_out_t;

endpackage

>>> hdl/rmq_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module rmq_sqrt import rmq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  logic [SQ_IN_W-1:0] in_n,
  input  side_t              in_side,
  output logic               out_vld,
  output logic [ROOT_W-1:0]  out_root,
  output side_t              out_side
);

  typedef struct packed {
    logic [SQ_W-1:0] n;
    logic [SQ_W-1:0] res;
    side_t           side;
  } sq_stg_t;

  sq_stg_t stg [SQ_STEPS];
  logic    vld [SQ_STEPS];

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_step
    localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (2 * (SQ_STEPS - 1 - g));
    sq_stg_t cur;
    sq_stg_t nxt;
    logic    cur_vld;
    logic [SQ_W-1:0] trial;

    if (g == 0) begin : g_first
      assign cur.n    = SQ_W'(in_n);
      assign cur.res  = '0;
      assign cur.side = in_side;
      assign cur_vld  = in_vld;
    end else begin : g_rest
      assign cur     = stg[g-1];
      assign cur_vld = vld[g-1];
    end

    always_comb begin
      trial    = cur.res + BITV;
      nxt.side = cur.side;
      if (cur.n >= trial) begin
        nxt.n   = cur.n - trial;
        nxt.res = (cur.res >> 1) + BITV;
      end else begin
        nxt.n   = cur.n;
        nxt.res = cur.res >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg[g] <= nxt;
      end
    end
  end

  assign out_vld  = vld[SQ_STEPS-1];
  assign out_root = stg[SQ_STEPS-1].res[ROOT_W-1:0];
  assign out_side = stg[SQ_STEPS-1].side;

endmodule

>>> hdl/rmq_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_div
// Three-lane pipelined restoring divider: |d| * 2^FRAC_BITS / (4c), rounded.
// ----------------------------------------------------------------------------
module rmq_div import rmq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [ROOT_W-1:0]        in_c,
  input  logic [LANES-1:0][OW-1:0] in_d,
  input  meta_t                    in_meta,
  output logic                     out_vld,
  output div_out_t                 out_res
);

  typedef struct packed {
    logic [ROOT_W-1:0]           c;
    logic [LANES-1:0][NUM_W-1:0] rem;
    logic [LANES-1:0][QW-1:0]    q;
    logic [LANES-1:0]            neg;
    logic [LANES-1:0]            ovf;
    meta_t                       meta;
  } dv_stg_t;

  localparam int NST = DIV_STEPS + 1;

  dv_stg_t stg [NST];
  logic    vld [NST];
  dv_stg_t prep;

  // Prepare the rounded numerator; quotients of 2^QW or more only saturate.
  always_comb begin
    logic [OW-1:0]    mag;
    logic [DEN_W-1:0] den;
    den       = {in_c, 2'b00};
    prep.c    = in_c;
    prep.meta = in_meta;
    prep.q    = '0;
    for (int k = 0; k < LANES; k++) begin
      mag         = in_d[k][OW-1] ? OW'(-in_d[k]) : in_d[k];
      prep.neg[k] = in_d[k][OW-1];
      prep.rem[k] = NUM_W'({mag, FRAC_BITS'(0)}) + NUM_W'({in_c, 1'b0});
      prep.ovf[k] = CMP_W'(prep.rem[k]) >= {den, QW'(0)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg[0] <= prep;
    end
  end

  for (genvar j = 1; j < NST; j++) begin : g_step
    localparam int B = QW - j;
    dv_stg_t nxt;

    always_comb begin
      logic [CMP_W-1:0] sh;
      nxt = stg[j-1];
      sh  = CMP_W'({stg[j-1].c, 2'b00}) << B;
      for (int k = 0; k < LANES; k++) begin
        if (CMP_W'(stg[j-1].rem[k]) >= sh) begin
          nxt.rem[k]  = stg[j-1].rem[k] - sh[NUM_W-1:0];
          nxt.q[k][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= vld[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg[j] <= nxt;
      end
    end
  end

  assign out_vld      = vld[NST-1];
  assign out_res.c    = stg[NST-1].c;
  assign out_res.q    = stg[NST-1].q;
  assign out_res.neg  = stg[NST-1].neg;
  assign out_res.ovf  = stg[NST-1].ovf;
  assign out_res.meta = stg[NST-1].meta;

endmodule

>>> hdl/rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps
// Throughput: one matrix per cycle while the output is not stalled.
// Every stage is a register with a valid bit.
// The square-root pipe (15 stages) and divider pipe (18 stages) set the depth.
// All stages advance together whenever the output register is empty or taken.
// Reset clears only the valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Shepperd conversion of a Q1.14 rotation matrix to a Q1.14 quaternion.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion import rmq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [EW-1:0] e00,
  input  logic signed [EW-1:0] e01,
  input  logic signed [EW-1:0] e02,
  input  logic signed [EW-1:0] e10,
  input  logic signed [EW-1:0] e11,
  input  logic signed [EW-1:0] e12,
  input  logic signed [EW-1:0] e20,
  input  logic signed [EW-1:0] e21,
  input  logic signed [EW-1:0] e22,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [EW-1:0] qx,
  output logic signed [EW-1:0] qy,
  output logic signed [EW-1:0] qz,
  output logic signed [EW-1:0] qw,
  output logic                 degenerate
);

  localparam logic signed [AW-1:0] ONE = AW'(1) << FRAC_BITS;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Input register, stored transposed: t<r><c> holds e<c><r>.
  logic signed [EW-1:0] t00, t01, t02, t10, t11, t12, t20, t21, t22;
  logic                 t_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_vld <= 1'b0;
    end else if (en) begin
      t_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t00 <= e00; t01 <= e10; t02 <= e20;
      t10 <= e01; t11 <= e11; t12 <= e21;
      t20 <= e02; t21 <= e12; t22 <= e22;
    end
  end

  // Branch selection. Lanes hold the non-dominant components in x, y, z, w order.
  logic signed [AW-1:0] trace, arg_next;
  side_t                side_next;

  always_comb begin
    trace = AW'(t00) + AW'(t11) + AW'(t22);
    if (trace > 0) begin
      side_next.meta.big = BIG_W;
      arg_next           = trace + ONE;
      side_next.d[0]     = OW'(t21) - OW'(t12);
      side_next.d[1]     = OW'(t02) - OW'(t20);
      side_next.d[2]     = OW'(t10) - OW'(t01);
    end else if (t00 > t11 && t00 > t22) begin
      side_next.meta.big = BIG_X;
      arg_next           = AW'(t00) - AW'(t11) - AW'(t22) + ONE;
      side_next.d[0]     = OW'(t10) + OW'(t01);
      side_next.d[1]     = OW'(t02) + OW'(t20);
      side_next.d[2]     = OW'(t21) - OW'(t12);
    end else if (t11 > t22) begin
      side_next.meta.big = BIG_Y;
      arg_next           = AW'(t11) - AW'(t00) - AW'(t22) + ONE;
      side_next.d[0]     = OW'(t10) + OW'(t01);
      side_next.d[1]     = OW'(t21) + OW'(t12);
      side_next.d[2]     = OW'(t02) - OW'(t20);
    end else begin
      side_next.meta.big = BIG_Z;
      arg_next           = AW'(t22) - AW'(t00) - AW'(t11) + ONE;
      side_next.d[0]     = OW'(t02) + OW'(t20);
      side_next.d[1]     = OW'(t21) + OW'(t12);
      side_next.d[2]     = OW'(t10) - OW'(t01);
    end
    side_next.meta.degen = (arg_next <= 0);
  end

  side_t                s_side;
  logic signed [AW-1:0] s_arg;
  logic                 s_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= 1'b0;
    end else if (en) begin
      s_vld <= t_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_side <= side_next;
      s_arg  <= arg_next;
    end
  end

  // A degenerate argument takes a zero radicand; its outputs are forced to zero later.
  logic [SQ_IN_W-1:0] radicand;
  assign radicand = s_side.meta.degen ? '0 : {s_arg[ARG_W-1:0], (FRAC_BITS - 2)'(0)};

  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  side_t             sq_side;

  rmq_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s_vld),
    .in_n     (radicand),
    .in_side  (s_side),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  logic     dv_vld;
  div_out_t dv_res;

  rmq_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (sq_vld),
    .in_c    (sq_root),
    .in_d    (sq_side.d),
    .in_meta (sq_side.meta),
    .out_vld (dv_vld),
    .out_res (dv_res)
  );

  function automatic logic [EW-1:0] sat_lane(input logic [QW-1:0] mag, input logic neg,
                                             input logic ovf);
    logic [EW-1:0] r;
    if (!neg) begin
      r = (ovf || mag > QW'(32767)) ? EW'(32767) : mag[EW-1:0];
    end else begin
      r = (ovf || mag > QW'(32768)) ? EW'(32768) : EW'(QW'(0) - mag);
    end
    return r;
  endfunction

  logic [EW-1:0] l0, l1, l2, cbig;
  logic [EW-1:0] qx_next, qy_next, qz_next, qw_next;

  always_comb begin
    l0   = sat_lane(dv_res.q[0], dv_res.neg[0], dv_res.ovf[0]);
    l1   = sat_lane(dv_res.q[1], dv_res.neg[1], dv_res.ovf[1]);
    l2   = sat_lane(dv_res.q[2], dv_res.neg[2], dv_res.ovf[2]);
    cbig = EW'(dv_res.c);
    case (dv_res.meta.big)
      BIG_X: begin
        qx_next = cbig; qy_next = l0; qz_next = l1; qw_next = l2;
      end
      BIG_Y: begin
        qx_next = l0; qy_next = cbig; qz_next = l1; qw_next = l2;
      end
      BIG_Z: begin
        qx_next = l0; qy_next = l1; qz_next = cbig; qw_next = l2;
      end
      default: begin
        qx_next = l0; qy_next = l1; qz_next = l2; qw_next = cbig;
      end
    endcase
    if (dv_res.meta.degen) begin
      qx_next = '0; qy_next = '0; qz_next = '0; qw_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qx         <= qx_next;
      qy         <= qy_next;
      qz         <= qz_next;
      qw         <= qw_next;
      degenerate <= dv_res.meta.degen;
    end
  end

`ifndef SYNTHESIS
  a_rst_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_trace_not_degen: assert property (@(posedge clk) disable iff (rst)
    s_vld && s_side.meta.degen |-> s_side.meta.big != BIG_W)
    else $error("trace branch flagged degenerate");

  a_root_range: assert property (@(posedge clk) disable iff (rst)
    sq_vld |-> sq_root <= ROOT_W'(23170))
    else $error("square root beyond argument range");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> qx == 0 && qy == 0 && qz == 0 && qw == 0)
    else $error("degenerate result with nonzero components");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    dv_vld && !en |=> dv_vld && $stable(dv_res))
    else $error("divider output changed during a stall");
`endif

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix-to-quaternion regression
// Drives directed and random 3x3 Q1.14 matrices through the pipe with random
// gaps and output stalls, predicts each quaternion in integer arithmetic and
// compares every result field in order of arrival.
// ----------------------------------------------------------------------------
module testbench;
  import rmq_pkg::*;

  typedef struct packed {
    logic [8:0][EW-1:0] e;   // index r*3+c holds e<r><c>
  } matrix_t;

  typedef struct packed {
    logic [EW-1:0] x;
    logic [EW-1:0] y;
    logic [EW-1:0] z;
    logic [EW-1:0] w;
    logic          degen;
  } quat_t;

  localparam int N_RANDOM = 1100;
  localparam int ONE = 1 << FRAC_BITS;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [EW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [EW-1:0] qx, qy, qz, qw;
  logic degenerate;

  matrix_t pending_matrices[$];
  quat_t   expected_quats[$];
  int      n_errors = 0;
  int      n_checked = 0;
  int      n_degen = 0;
  int      n_sent = 0;
  bit      hold_sender = 0;
  int      send_gap = 0;
  int      recv_gap = 0;

  rotation_matrix_to_quaternion u_top (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Off-diagonal term over 4c, rounded half away from zero.
  function automatic longint div_by_root(longint d, longint unsigned c);
    longint unsigned mag, q;
    longint r;
    mag = (d < 0) ? -d : d;
    q = ((mag << FRAC_BITS) + 2 * c) / (4 * c);
    r = (q > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : q;
    return (d < 0) ? -r : r;
  endfunction

  function automatic quat_t predict_quat(matrix_t m);
    longint t[3][3];
    longint q[4];
    longint a, tr;
    longint unsigned c;
    bit dg;
    quat_t res;
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++)
        t[r][k] = longint'($signed(m.e[k * 3 + r]));
    q = '{0, 0, 0, 0};
    dg = 0;
    tr = t[0][0] + t[1][1] + t[2][2];
    if (tr > 0) begin
      c = int_sqrt(longint'(tr + ONE) << (FRAC_BITS - 2));
      q[3] = c;
      q[0] = div_by_root(t[2][1] - t[1][2], c);
      q[1] = div_by_root(t[0][2] - t[2][0], c);
      q[2] = div_by_root(t[1][0] - t[0][1], c);
    end else if (t[0][0] > t[1][1] && t[0][0] > t[2][2]) begin
      a = t[0][0] - t[1][1] - t[2][2] + ONE;
      if (a <= 0) dg = 1;
      else begin
        c = int_sqrt(a << (FRAC_BITS - 2));
        q[0] = c;
        q[1] = div_by_root(t[1][0] + t[0][1], c);
        q[2] = div_by_root(t[0][2] + t[2][0], c);
        q[3] = div_by_root(t[2][1] - t[1][2], c);
      end
    end else if (t[1][1] > t[2][2]) begin
      a = t[1][1] - t[0][0] - t[2][2] + ONE;
      if (a <= 0) dg = 1;
      else begin
        c = int_sqrt(a << (FRAC_BITS - 2));
        q[1] = c;
        q[0] = div_by_root(t[1][0] + t[0][1], c);
        q[2] = div_by_root(t[2][1] + t[1][2], c);
        q[3] = div_by_root(t[0][2] - t[2][0], c);
      end
    end else begin
      a = t[2][2] - t[0][0] - t[1][1] + ONE;
      if (a <= 0) dg = 1;
      else begin
        c = int_sqrt(a << (FRAC_BITS - 2));
        q[2] = c;
        q[0] = div_by_root(t[0][2] + t[2][0], c);
        q[1] = div_by_root(t[2][1] + t[1][2], c);
        q[3] = div_by_root(t[1][0] - t[0][1], c);
      end
    end
    res.x = EW'(sat16(q[0]));
    res.y = EW'(sat16(q[1]));
    res.z = EW'(sat16(q[2]));
    res.w = EW'(sat16(q[3]));
    res.degen = dg;
    return res;
  endfunction

  function automatic matrix_t diag_matrix(int a, int b, int c);
    matrix_t m;
    m = '0;
    m.e[0] = EW'(a);
    m.e[4] = EW'(b);
    m.e[8] = EW'(c);
    return m;
  endfunction

  // Entry scaled to mostly stay near the unit range, sometimes full range.
  function automatic logic [EW-1:0] rand_entry();
    case ($urandom_range(0, 9))
      0: return EW'($urandom);
      1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return EW'($signed($urandom_range(0, 2 * ONE)) - ONE);
    endcase
  endfunction

  function automatic matrix_t rand_matrix();
    matrix_t m;
    int mode;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < 9; i++) m.e[i] = rand_entry();
    // Push the trace negative so the diagonal branches and ties get exercised.
    if (mode == 1) begin
      for (int i = 0; i < 9; i += 4) m.e[i] = EW'(-$signed($urandom_range(0, ONE)));
    end else if (mode == 2) begin
      m.e[0] = EW'(-$signed($urandom_range(0, ONE)));
      m.e[4] = m.e[0];
      m.e[8] = $urandom_range(0, 1) ? m.e[0] : rand_entry();
    end
    return m;
  endfunction

  // Driver.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      send_gap <= $urandom_range(0, 7);
    end else if (in_valid && !in_ready) begin
      // Hold the transaction until accepted.
    end else if (send_gap > 0 || hold_sender || pending_matrices.size() == 0) begin
      in_valid <= 0;
      if (send_gap > 0) send_gap <= send_gap - 1;
    end else begin
      matrix_t m;
      m = pending_matrices.pop_front();
      expected_quats.push_back(predict_quat(m));
      {e22, e21, e20, e12, e11, e10, e02, e01, e00} <= m.e;
      in_valid <= 1;
      n_sent <= n_sent + 1;
      // Bursts without gaps happen for a stretch every few hundred items.
      send_gap <= ((n_sent / 200) % 2 == 1) ? 0 : $urandom_range(0, 7);
    end
  end

  // Monitor.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
      recv_gap <= $urandom_range(0, 7);
    end else begin
      if (out_valid && out_ready) begin
        if (expected_quats.size() == 0) begin
          $error("unexpected result qx=%0d qy=%0d qz=%0d qw=%0d", qx, qy, qz, qw);
          n_errors++;
        end else begin
          quat_t ex;
          ex = expected_quats.pop_front();
          if (qx !== ex.x) begin
            $error("qx: expected %0d, got %0d", $signed(ex.x), qx); n_errors++;
          end
          if (qy !== ex.y) begin
            $error("qy: expected %0d, got %0d", $signed(ex.y), qy); n_errors++;
          end
          if (qz !== ex.z) begin
            $error("qz: expected %0d, got %0d", $signed(ex.z), qz); n_errors++;
          end
          if (qw !== ex.w) begin
            $error("qw: expected %0d, got %0d", $signed(ex.w), qw); n_errors++;
          end
          if (degenerate !== ex.degen) begin
            $error("degenerate: expected %0d, got %0d", ex.degen, degenerate);
            n_errors++;
          end
          if (ex.degen) n_degen++;
          n_checked++;
        end
      end
      if (out_ready && out_valid || !out_ready) begin
        if (recv_gap > 0) begin
          out_ready <= 0;
          recv_gap <= recv_gap - 1;
        end else begin
          out_ready <= 1;
          recv_gap <= ((n_checked / 300) % 2 == 1) ? 0 : $urandom_range(0, 7);
        end
      end
    end
  end

  initial begin
    rst = 1;
    in_valid = 0;
    out_ready = 0;
    {e00, e01, e02, e10, e11, e12, e20, e21, e22} = '0;
    repeat (11) @(posedge clk);
    rst <= 0;

    // Directed: identity, sign extremes, every branch and ties.
    pending_matrices.push_back(diag_matrix(ONE, ONE, ONE));
    pending_matrices.push_back(diag_matrix(ONE, -ONE, -ONE));
    pending_matrices.push_back(diag_matrix(-ONE, ONE, -ONE));
    pending_matrices.push_back(diag_matrix(-ONE, -ONE, ONE));
    pending_matrices.push_back(diag_matrix(0, 0, 0));
    pending_matrices.push_back(diag_matrix(-ONE, -ONE, -ONE));
    pending_matrices.push_back(diag_matrix(-32768, -32768, -32768));
    pending_matrices.push_back(diag_matrix(32767, 32767, 32767));
    pending_matrices.push_back(diag_matrix(-100, -100, -200));
    pending_matrices.push_back(diag_matrix(-200, -100, -100));
    pending_matrices.push_back(diag_matrix(32767, -32768, -32768));
    begin
      matrix_t m;
      m.e = {9{16'h7FFF}};
      pending_matrices.push_back(m);
      m.e = {9{16'h8000}};
      pending_matrices.push_back(m);
      m.e = {9{16'hFFFF}};
      pending_matrices.push_back(m);
      m.e = {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
             16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
      pending_matrices.push_back(m);
      m.e = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0001,
             16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
      pending_matrices.push_back(m);
      // Z-branch matrix with unit off-diagonals, then trace at zero with tiny diagonals.
      m = diag_matrix(-ONE, -ONE, ONE);
      m.e[1] = EW'(ONE);
      m.e[3] = EW'(-ONE);
      pending_matrices.push_back(m);
      m = diag_matrix(1, 0, -1);
      m.e[5] = 16'h8000;
      m.e[7] = 16'h7FFF;
      pending_matrices.push_back(m);
    end

    // Let the pipe drain completely once before the random part.
    wait (pending_matrices.size() == 0);
    hold_sender = 1;
    wait (expected_quats.size() == 0 && !in_valid);
    hold_sender = 0;

    for (int i = 0; i < N_RANDOM; i++) begin
      pending_matrices.push_back(rand_matrix());
      if (i % 100 == 99) wait (pending_matrices.size() < 20);
    end
    wait (pending_matrices.size() == 0 && !in_valid);
    wait (expected_quats.size() == 0);
    repeat (60) @(posedge clk);

    $display("Checked %0d quaternions (%0d degenerate) across all Shepperd branches,",
             n_checked, n_degen);
    $display("with random input gaps and output stalls.");
    if (n_errors == 0 && expected_quats.size() == 0) begin
      $display("rotation_matrix_to_quaternion regression: pass");
    end else begin
      $display("rotation_matrix_to_quaternion regression: fail");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("rotation_matrix_to_quaternion regression: fail");
    $finish;
  end

endmodule
